FILE: rtl/core/rrt_pkg.sv
// Shared types and constants for the request retry tracker.
`timescale 1ns / 1ps

package rrt_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned SEQ_W     = 6;
  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned TMR_W     = 8;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned STATUS_W  = 4;
  localparam int unsigned IDX_OUT_W = 4;

  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 8;

  typedef enum logic [S_TUSER_W-1:0] {
    ACT_SUBMIT   = 2'd0,
    ACT_RESPONSE = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_SCAN     = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED  = 4'd0,
    ST_FULL      = 4'd1,
    ST_MATCHED   = 4'd2,
    ST_UNMATCHED = 4'd3,
    ST_TICKED    = 4'd4,
    ST_FIRST     = 4'd5,
    ST_RESEND    = 4'd6,
    ST_GIVEUP    = 4'd7,
    ST_IDLE      = 4'd8
  } status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_SWEEP
  } fsm_e;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRY_LIMIT     = 1'd1;

  localparam logic [CFG_W-1:0] TIMEOUT_RST   = 8'd3;
  localparam logic [CFG_W-1:0] TRY_LIMIT_RST = 8'd5;

  localparam logic [TMR_W-1:0] TMR_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
    logic [TMR_W-1:0]  tmr;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/core/request_retry_tracker_core.sv
// Request retry tracker: outstanding request table with timed resend.
//
//   port group    dir  beat contents
//   s_axis_*      in   tuser: action; tdata: seq, responder addr, queue ready
//   m_axis_*      out  tuser: status; tdata: entry index, sent; tlast: last
//   cfg_*         in   register write: timeout ticks (0), try limit (1)
//
// Every request sweeps the table through one RAM read port, one entry per cycle.
// A full sweep loads its result once every entry has been read, and the next request
// is taken after that load; a submit, match, first send or resend at entry k ends the
// sweep there. A give-up held ahead of a send goes out first and holds the sweep.
// The sweep holds while the result register is full and not taken.
// Reset empties the table at once; tag RAM contents need no clearing.
`timescale 1ns / 1ps

module request_retry_tracker_core #(
  parameter int unsigned TABLE_DEPTH = rrt_pkg::DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rrt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rrt_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [5:0] sequence_number, [13:6] responder_address, [14] queue_ready, [15] zero
  input  logic [rrt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] action
  input  logic [rrt_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [3:0] table slot, [4] sent, [7:5] zero
  output logic [rrt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // [3:0] status
  output logic [rrt_pkg::STATUS_W-1:0]   m_axis_tuser,
  output logic                           m_axis_tlast
);

  import rrt_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned PTR_W = $clog2(TABLE_DEPTH + 1);

  fsm_e                   state_q, state_d;
  action_e                act_q;
  logic [SEQ_W-1:0]       seq_q;
  logic [ADDR_W-1:0]      addr_q;
  logic                   qrdy_q;
  logic [CFG_W-1:0]       timeout_q;
  logic [CFG_W-1:0]       limit_q;
  logic [TABLE_DEPTH-1:0] occ_q;
  logic [PTR_W-1:0]       rd_cnt_q;
  logic                   ev_vld_q;
  logic [IDX_W-1:0]       ev_idx_q;
  logic                   pend_vld_q;
  logic [IDX_W-1:0]       pend_idx_q;
  logic                   out_vld_q;
  status_e                out_status_q;
  logic [IDX_OUT_W-1:0]   out_idx_q;
  logic                   out_sent_q;
  logic                   out_last_q;

  entry_t ev_ent;
  logic   accept;
  logic   rd_more;
  logic   occ_e;

  logic    r_emit, r_sent, r_done, r_giveup, r_wr, occ_set, occ_clr;
  status_e r_status;
  entry_t  r_wdata;

  logic out_free, flush, commit, advance, sweep_end, ram_re;

  logic    out_load;
  status_e out_status_d;
  logic [IDX_W-1:0] out_idx_sel;
  logic    out_sent_d, out_last_d;
  status_e end_status;
  logic [IDX_W+IDX_OUT_W-1:0] out_idx_ext;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign rd_more = rd_cnt_q < PTR_W'(TABLE_DEPTH);
  assign occ_e   = occ_q[ev_idx_q];

  rrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (commit && r_wr),
    .waddr_i (ev_idx_q),
    .wdata_i (r_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_cnt_q[IDX_W-1:0]),
    .rdata_o (ev_ent)
  );

  // per-entry evaluation
  always_comb begin
    r_emit   = 1'b0;
    r_status = ST_IDLE;
    r_sent   = 1'b0;
    r_done   = 1'b0;
    r_giveup = 1'b0;
    r_wr     = 1'b0;
    occ_set  = 1'b0;
    occ_clr  = 1'b0;
    r_wdata  = ev_ent;
    unique case (act_q)
      ACT_SUBMIT: begin
        if (!occ_e) begin
          r_emit        = 1'b1;
          r_status      = ST_ACCEPTED;
          r_sent        = qrdy_q;
          r_done        = 1'b1;
          r_wr          = 1'b1;
          occ_set       = 1'b1;
          r_wdata.seq   = seq_q;
          r_wdata.addr  = addr_q;
          r_wdata.cnt   = CNT_W'(qrdy_q);
          r_wdata.tmr   = '0;
        end
      end
      ACT_RESPONSE: begin
        if (occ_e && ev_ent.seq == seq_q && ev_ent.addr == addr_q) begin
          r_emit   = 1'b1;
          r_status = ST_MATCHED;
          r_done   = 1'b1;
          occ_clr  = 1'b1;
        end
      end
      ACT_TICK: begin
        if (occ_e && ev_ent.cnt != '0 && ev_ent.tmr != TMR_MAX) begin
          r_wr        = 1'b1;
          r_wdata.tmr = ev_ent.tmr + TMR_W'(1);
        end
      end
      ACT_SCAN: begin
        if (occ_e) begin
          if (ev_ent.cnt == '0) begin
            r_emit   = 1'b1;
            r_status = ST_FIRST;
            r_sent   = qrdy_q;
            r_done   = 1'b1;
            if (qrdy_q) begin
              r_wr        = 1'b1;
              r_wdata.cnt = CNT_W'(1);
              r_wdata.tmr = '0;
            end
          end else if (ev_ent.tmr >= timeout_q) begin
            if (ev_ent.cnt >= limit_q) begin
              r_giveup = 1'b1;
              occ_clr  = 1'b1;
            end else begin
              r_emit      = 1'b1;
              r_status    = ST_RESEND;
              r_sent      = qrdy_q;
              r_done      = 1'b1;
              r_wr        = 1'b1;
              r_wdata.tmr = '0;
              if (ev_ent.cnt != CNT_MAX) begin
                r_wdata.cnt = ev_ent.cnt + CNT_W'(1);
              end
            end
          end
        end
      end
    endcase
  end

  // sweep control; a pending give-up goes out before a first send or resend
  assign out_free  = !out_vld_q || m_axis_tready;
  assign flush     = ev_vld_q && out_free && pend_vld_q && r_done;
  assign commit    = ev_vld_q && out_free && !flush;
  assign advance   = (state_q == FSM_SWEEP) && (!ev_vld_q || commit) && !(commit && r_done);
  assign sweep_end = (state_q == FSM_SWEEP) && !ev_vld_q && !rd_more && out_free;
  assign ram_re    = advance && rd_more;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_SWEEP;
        end
      end
      FSM_SWEEP: begin
        if ((commit && r_done) || sweep_end) begin
          state_d = FSM_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    unique case (act_q)
      ACT_SUBMIT:   end_status = ST_FULL;
      ACT_RESPONSE: end_status = ST_UNMATCHED;
      ACT_TICK:     end_status = ST_TICKED;
      ACT_SCAN:     end_status = ST_IDLE;
    endcase
  end

  // result register load
  always_comb begin
    out_load     = 1'b0;
    out_status_d = ST_GIVEUP;
    out_idx_sel  = pend_idx_q;
    out_sent_d   = 1'b0;
    out_last_d   = 1'b0;
    priority if (flush) begin
      out_load = 1'b1;
    end else if (commit && r_emit) begin
      out_load     = 1'b1;
      out_status_d = r_status;
      out_idx_sel  = ev_idx_q;
      out_sent_d   = r_sent;
      out_last_d   = 1'b1;
    end else if (commit && r_giveup && pend_vld_q) begin
      out_load = 1'b1;
    end else if (sweep_end) begin
      out_load   = 1'b1;
      out_last_d = 1'b1;
      if (!pend_vld_q) begin
        out_status_d = end_status;
        out_idx_sel  = '0;
      end
    end else begin
      out_load = 1'b0;
    end
  end

  assign out_idx_ext = {IDX_OUT_W'(0), out_idx_sel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FSM_IDLE;
      timeout_q  <= TIMEOUT_RST;
      limit_q    <= TRY_LIMIT_RST;
      occ_q      <= '0;
      rd_cnt_q   <= '0;
      ev_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TIMEOUT_TICKS) begin
          timeout_q <= cfg_data_i;
        end else if (cfg_idx_i == CFG_TRY_LIMIT) begin
          limit_q <= cfg_data_i;
        end
      end

      if (accept) begin
        rd_cnt_q <= '0;
        ev_vld_q <= 1'b0;
      end else if (advance) begin
        ev_vld_q <= rd_more;
        if (rd_more) begin
          rd_cnt_q <= rd_cnt_q + PTR_W'(1);
        end
      end else if (commit && r_done) begin
        ev_vld_q <= 1'b0;
      end

      if (commit && occ_set) begin
        occ_q[ev_idx_q] <= 1'b1;
      end else if (commit && occ_clr) begin
        occ_q[ev_idx_q] <= 1'b0;
      end

      if (accept || flush || sweep_end) begin
        pend_vld_q <= 1'b0;
      end else if (commit && r_giveup) begin
        pend_vld_q <= 1'b1;
      end

      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_e'(s_axis_tuser);
      seq_q  <= s_axis_tdata[5:0];
      addr_q <= s_axis_tdata[13:6];
      qrdy_q <= s_axis_tdata[14];
    end
    if (ram_re) begin
      ev_idx_q <= rd_cnt_q[IDX_W-1:0];
    end
    if (commit && r_giveup) begin
      pend_idx_q <= ev_idx_q;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_idx_q    <= out_idx_ext[IDX_OUT_W-1:0];
      out_sent_q   <= out_sent_d;
      out_last_q   <= out_last_d;
    end
  end

  assign s_axis_tready = (state_q == FSM_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_sent_q, out_idx_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  a_pend_only_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (act_q == ACT_SCAN))
    else $error("pending give-up outside a service scan");

  a_done_no_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && r_done) |-> !pend_vld_q)
    else $error("final result committed ahead of a pending give-up");

  a_occ_idle_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_IDLE) |=> (occ_q == $past(occ_q)))
    else $error("table occupancy changed while idle");

endmodule

FILE: rtl/core/rrt_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module rrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
